@@ design/tmdc_pkg.sv @@
// Package: shared constants and types for the text-mode display controller.
`timescale 1ns / 1ps
package tmdc_pkg;
  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int GLYPH_WIDTH = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int PALETTE_ENTRIES = 16;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CHAR_BYTES = CELL_COUNT * 2;
  localparam int PAL_BYTES = PALETTE_ENTRIES * 3;
  localparam int ATLAS_GLYPHS = 128;
  localparam int FONT_DEPTH = 32768;
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int PAL_AW = $clog2(PAL_BYTES);
  localparam int FONT_AW = 15;
  localparam int CX_W = 10;
  localparam int CY_W = 9;
  localparam int FONT_THRESHOLD = 127;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;
  localparam logic [1:0] CMD_FONT = 2'd3;

  localparam logic [1:0] REG_CHAR_BASE = 2'd0;
  localparam logic [1:0] REG_PAL_BASE = 2'd1;
  localparam logic [1:0] REG_VSYNC = 2'd2;

  // Operation kinds after classification.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_CHAR_RD = 3'd1;
  localparam logic [2:0] OP_CHAR_WR = 3'd2;
  localparam logic [2:0] OP_PAL_RD = 3'd3;
  localparam logic [2:0] OP_PAL_WR = 3'd4;
  localparam logic [2:0] OP_VSYNC = 3'd5;
  localparam logic [2:0] OP_PIXEL = 3'd6;
  localparam logic [2:0] OP_FONT = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [CELL_AW:0] char_off;
    logic [PAL_AW-1:0] pal_off;
    logic [7:0] data;
    logic [CELL_AW-1:0] cell_index;
    logic [3:0] sub_x;
    logic [4:0] sub_y;
    logic [FONT_AW-1:0] font_addr;
  } tmdc_op_t;
endpackage

@@ design/tmdc_front.sv @@
// Front end: address decode and pixel-to-cell classification of input items.
`timescale 1ns / 1ps
module tmdc_front (
  input  logic [1:0] command,
  input  logic [15:0] bus_address,
  input  logic [7:0] write_data,
  input  logic [9:0] pixel_x,
  input  logic [8:0] pixel_y,
  input  logic [14:0] font_index,
  input  logic [15:0] char_region_base,
  input  logic [15:0] palette_region_base,
  input  logic [15:0] vsync_strobe_address,
  output tmdc_pkg::tmdc_op_t op
);
  import tmdc_pkg::*;
  logic [16:0] char_diff;
  logic [16:0] pal_diff;
  logic hit_char;
  logic hit_pal;
  logic hit_vs;
  logic [CX_W-1:0] cx;
  logic [CY_W-1:0] cy;
  logic [17:0] cell_full;

  always_comb begin
    char_diff = {1'b0, bus_address} - {1'b0, char_region_base};
    pal_diff = {1'b0, bus_address} - {1'b0, palette_region_base};
    hit_char = !char_diff[16] && (char_diff < 17'(CHAR_BYTES));
    hit_pal = !pal_diff[16] && (pal_diff < 17'(PAL_BYTES));
    hit_vs = bus_address == vsync_strobe_address;
    // Constant divisors fold to shifts for the default glyph size.
    cx = CX_W'(pixel_x / GLYPH_WIDTH);
    cy = CY_W'(pixel_y / GLYPH_HEIGHT);
    cell_full = 18'(cy) * 18'(COLUMNS) + 18'(cx);
    op.char_off = char_diff[CELL_AW:0];
    op.pal_off = pal_diff[PAL_AW-1:0];
    op.data = write_data;
    op.cell_index = cell_full[CELL_AW-1:0];
    op.sub_x = 4'(pixel_x % GLYPH_WIDTH);
    op.sub_y = 5'(pixel_y % GLYPH_HEIGHT);
    op.font_addr = font_index;
    op.op = OP_NONE;
    case (command)
      CMD_READ: begin
        if (hit_char) op.op = OP_CHAR_RD;
        else if (hit_pal) op.op = OP_PAL_RD;
      end
      CMD_WRITE: begin
        if (hit_char) op.op = OP_CHAR_WR;
        else if (hit_pal) op.op = OP_PAL_WR;
        else if (hit_vs) op.op = OP_VSYNC;
      end
      CMD_PIXEL: begin
        if (32'(cx) < COLUMNS && 32'(cy) < ROWS) op.op = OP_PIXEL;
      end
      default: op.op = OP_FONT;
    endcase
  end
endmodule

@@ design/tmdc_queue.sv @@
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module tmdc_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tmdc_pkg::tmdc_op_t in_op,
  output logic out_valid,
  input  logic out_ready,
  output tmdc_pkg::tmdc_op_t out_op
);
  import tmdc_pkg::*;
  tmdc_op_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  assign in_ready = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_op = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_op;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ design/tmdc_back.sv @@
// Back end: memory sequencer for cells, palette and font, with output register.
`timescale 1ns / 1ps
module tmdc_back (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  tmdc_pkg::tmdc_op_t op,
  output logic valid,
  input  logic ready,
  output logic [7:0] read_data,
  output logic accepted,
  output logic vsync_pulse,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import tmdc_pkg::*;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CELL = 3'd1;
  localparam logic [2:0] ST_FONT = 3'd2;
  localparam logic [2:0] ST_PAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  logic [7:0] code_mem [CELL_COUNT];
  logic [7:0] attr_mem [CELL_COUNT];
  logic font_mem [FONT_DEPTH];
  logic [7:0] pal_r [PALETTE_ENTRIES];
  logic [7:0] pal_g [PALETTE_ENTRIES];
  logic [7:0] pal_b [PALETTE_ENTRIES];

  logic [2:0] state;
  logic [CELL_AW-1:0] clr_addr;
  tmdc_op_t cur;
  logic [7:0] code_q;
  logic [7:0] attr_q;
  logic font_q;
  logic [3:0] entry;
  logic [FONT_AW-1:0] font_rd_addr;
  logic [17:0] gx;
  logic [17:0] gy;
  logic [CELL_AW-1:0] cell_addr;
  logic [11:0] pal_prod;
  logic [1:0] pal_lane;
  logic [3:0] pal_idx;
  logic [7:0] sel_byte;

  assign op_ready = state == ST_IDLE && (!valid || ready);
  assign cell_addr = cur.char_off[CELL_AW:1];
  // Multiplying by 43/128 divides by three exactly for offsets below 48.
  assign pal_prod = 12'(cur.pal_off) * 12'd43;
  assign pal_idx = pal_prod[10:7];
  assign pal_lane = 2'(cur.pal_off - ({2'b00, pal_idx} + {1'b0, pal_idx, 1'b0}));

  always_comb begin
    gx = 18'(code_q[6:0]) * 18'(GLYPH_WIDTH) + 18'(cur.sub_x);
    gy = 18'(code_q[7]) * 18'(GLYPH_HEIGHT) + 18'(cur.sub_y);
    font_rd_addr = FONT_AW'(gy * 18'(ATLAS_GLYPHS * GLYPH_WIDTH) + gx);
    entry = font_q ? attr_q[3:0] : attr_q[7:4];
    case (pal_lane)
      2'd0: sel_byte = pal_r[pal_idx];
      2'd1: sel_byte = pal_g[pal_idx];
      default: sel_byte = pal_b[pal_idx];
    endcase
  end

  // Cell memories: one write and one read port each.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      code_mem[clr_addr] <= 8'd0;
      attr_mem[clr_addr] <= 8'h01;
    end else if (state == ST_CELL && cur.op == OP_CHAR_WR) begin
      if (cur.char_off[0]) attr_mem[cell_addr] <= cur.data;
      else code_mem[cell_addr] <= cur.data;
    end
    code_q <= code_mem[(cur.op == OP_PIXEL) ? cur.cell_index : cell_addr];
    attr_q <= attr_mem[(cur.op == OP_PIXEL) ? cur.cell_index : cell_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CELL && cur.op == OP_FONT) font_mem[cur.font_addr] <= cur.data > 8'(FONT_THRESHOLD);
    font_q <= font_mem[font_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        pal_r[i] <= (i == 1) ? 8'd255 : (i == 2) ? 8'd127 : 8'd0;
        pal_g[i] <= (i == 1) ? 8'd255 : 8'd0;
        pal_b[i] <= (i == 1) ? 8'd255 : 8'd0;
      end
    end else if (state == ST_CELL && cur.op == OP_PAL_WR) begin
      case (pal_lane)
        2'd0: pal_r[pal_idx] <= cur.data;
        2'd1: pal_g[pal_idx] <= cur.data;
        default: pal_b[pal_idx] <= cur.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) cur <= op;
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      valid <= 1'b0;
    end else begin
      if (valid && ready) valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == CELL_COUNT - 1) state <= ST_IDLE;
        end
        ST_IDLE: if (op_valid && op_ready) state <= ST_CELL;
        ST_CELL: begin
          read_data <= (cur.op == OP_PAL_RD) ? sel_byte : 8'd0;
          accepted <= cur.op != OP_NONE;
          vsync_pulse <= cur.op == OP_VSYNC;
          red <= 8'd0;
          green <= 8'd0;
          blue <= 8'd0;
          if (cur.op == OP_PIXEL) state <= ST_FONT;
          else if (cur.op == OP_CHAR_RD) state <= ST_DONE;
          else begin
            valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_FONT: state <= ST_PAL;
        ST_PAL: begin
          red <= pal_r[entry];
          green <= pal_g[entry];
          blue <= pal_b[entry];
          valid <= 1'b1;
          state <= ST_IDLE;
        end
        ST_DONE: begin
          read_data <= cur.char_off[0] ? attr_q : code_q;
          valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/text_mode_display_controller.sv @@
// Top level: text-mode display controller with configuration registers.
// Sequencing: writes and palette reads end in the cell state, character reads go
// on to a done state, pixel fetches pass the cell, font and palette states (cell
// read, font read, palette lookup in turn). The sequencer takes a new item only
// when idle with its output free. Reset: synchronous; clearing all 2000 cells
// precedes the first item; configuration writes are taken throughout.
`timescale 1ns / 1ps
module text_mode_display_controller (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] command,
  input  logic [15:0] bus_address,
  input  logic [7:0] write_data,
  input  logic [9:0] pixel_x,
  input  logic [8:0] pixel_y,
  input  logic [14:0] font_index,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] read_data,
  output logic accepted,
  output logic vsync_pulse,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import tmdc_pkg::*;
  logic [15:0] char_region_base;
  logic [15:0] palette_region_base;
  logic [15:0] vsync_strobe_address;
  tmdc_op_t front_op;
  tmdc_op_t q_op;
  logic q_valid;
  logic q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_region_base <= 16'd0;
      palette_region_base <= 16'd8192;
      vsync_strobe_address <= 16'hFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHAR_BASE: char_region_base <= cfg_data;
        REG_PAL_BASE: palette_region_base <= cfg_data;
        REG_VSYNC: vsync_strobe_address <= cfg_data;
        default: ;
      endcase
    end
  end

  tmdc_front u_front (
    .command(command), .bus_address(bus_address), .write_data(write_data),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .font_index(font_index),
    .char_region_base(char_region_base), .palette_region_base(palette_region_base),
    .vsync_strobe_address(vsync_strobe_address), .op(front_op)
  );

  tmdc_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_op(front_op),
    .out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
  );

  tmdc_back u_back (
    .clk(clk), .rst(rst), .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
    .valid(out_valid), .ready(out_ready), .read_data(read_data), .accepted(accepted),
    .vsync_pulse(vsync_pulse), .red(red), .green(green), .blue(blue)
  );
endmodule
